// ===== hdl/median_filter_3x3_defines.svh =====
// assertion macros shared by the median filter rtl
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge out of reset
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition now implies property in the next cycle
`define MF3_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define MF3_ASSERT(lbl, prop, msg)
`define MF3_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// ===== hdl/mf3_pkg.sv =====
package mf3_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int TDATA_BITS   = ((PIXEL_BITS + 7) / 8) * 8;

  // register field widths
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 21;
  localparam int HEIGHT_LIMIT  = 1048576;
  localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 21;

  localparam int WIN_SIZE = 9;
  localparam int WIN_MID  = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // one classified item handed from front to back
  typedef struct packed {
    pixel_t              pixel;
    logic [COL_BITS-1:0] col;
    logic                emit;
    logic                border;
    logic                fend;
  } item_t;

endpackage

// ===== hdl/mf3_queue.sv =====
`include "median_filter_3x3_defines.svh"

module mf3_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mf3_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output mf3_pkg::item_t pop_item,
  output logic           empty
);

  mf3_pkg::item_t                   mem_r [mf3_pkg::QUEUE_DEPTH];
  logic [mf3_pkg::QPTR_BITS-1:0]    wptr_r;
  logic [mf3_pkg::QPTR_BITS-1:0]    rptr_r;
  logic [mf3_pkg::QPTR_BITS:0]      count_r;

  assign full     = count_r == (mf3_pkg::QPTR_BITS + 1)'(mf3_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + mf3_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + mf3_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (mf3_pkg::QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (mf3_pkg::QPTR_BITS + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  `MF3_ASSERT(a_queue_guarded, !(push && full) && !(pop && empty), "queue overrun or underrun")

endmodule

// ===== hdl/mf3_front.sv =====
`include "median_filter_3x3_defines.svh"

module mf3_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mf3_pkg::TDATA_BITS-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               q_full,
  output logic                               q_push,
  output mf3_pkg::item_t                     q_item
);

  // how many input rows have been completed, saturating
  typedef enum logic [1:0] {
    ROWS_NONE,
    ROWS_ONE,
    ROWS_MANY
  } row_phase_t;

  row_phase_t                       phase_r;
  logic [mf3_pkg::COL_BITS-1:0]     w_m1_r;
  logic [mf3_pkg::ROW_BITS-1:0]     h_m1_r;
  logic [mf3_pkg::COL_BITS-1:0]     col_r;
  logic [mf3_pkg::COL_BITS-1:0]     ocol_r;
  logic [mf3_pkg::ROW_BITS-1:0]     orow_r;

  logic                             accept;
  logic                             col_last;
  logic                             ocol_last;
  logic                             orow_last;
  logic                             emit;
  logic                             fend;
  logic [mf3_pkg::WIDTH_BITS-1:0]   cfg_w;
  logic [mf3_pkg::HEIGHT_BITS-1:0]  cfg_h;
  logic [mf3_pkg::COL_BITS-1:0]     w_m1_nxt;
  logic [mf3_pkg::ROW_BITS-1:0]     h_m1_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;

  assign col_last  = col_r == w_m1_r;
  assign ocol_last = ocol_r == w_m1_r;
  assign orow_last = orow_r == h_m1_r;
  // a result is due once one row and one pixel have gone in
  assign emit      = (phase_r == ROWS_MANY) || ((phase_r == ROWS_ONE) && (col_r != '0));
  assign fend      = emit && orow_last && ocol_last;

  always_comb begin
    q_item.pixel  = in_tuser ? '0 : in_tdata[mf3_pkg::PIXEL_BITS-1:0];
    q_item.col    = col_r;
    q_item.emit   = emit;
    q_item.border = (orow_r == '0) || orow_last || (ocol_r == '0) || ocol_last;
    q_item.fend   = fend;
  end

  // saturate register values and keep them as size minus one
  assign cfg_w = cfg_data[mf3_pkg::WIDTH_BITS-1:0];
  assign cfg_h = cfg_data[mf3_pkg::HEIGHT_BITS-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      w_m1_nxt = '0;
    end else if (cfg_w > mf3_pkg::WIDTH_BITS'(mf3_pkg::MAX_WIDTH)) begin
      w_m1_nxt = mf3_pkg::COL_BITS'(mf3_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1_nxt = mf3_pkg::COL_BITS'(cfg_w - mf3_pkg::WIDTH_BITS'(1));
    end
    if (cfg_h == '0) begin
      h_m1_nxt = '0;
    end else if (cfg_h > mf3_pkg::HEIGHT_BITS'(mf3_pkg::HEIGHT_LIMIT)) begin
      h_m1_nxt = mf3_pkg::ROW_BITS'(mf3_pkg::HEIGHT_LIMIT - 1);
    end else begin
      h_m1_nxt = mf3_pkg::ROW_BITS'(cfg_h - mf3_pkg::HEIGHT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r  <= mf3_pkg::COL_BITS'(mf3_pkg::RESET_WIDTH - 1);
      h_m1_r  <= mf3_pkg::ROW_BITS'(mf3_pkg::RESET_HEIGHT - 1);
      phase_r <= ROWS_NONE;
      col_r   <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
    end else if (cfg_valid) begin
      unique case (mf3_pkg::cfg_reg_t'(cfg_index))
        mf3_pkg::REG_FRAME_WIDTH:  w_m1_r <= w_m1_nxt;
        mf3_pkg::REG_FRAME_HEIGHT: h_m1_r <= h_m1_nxt;
        default: ;
      endcase
      // any write restarts the frame
      phase_r <= ROWS_NONE;
      col_r   <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
    end else if (accept) begin
      if (fend) begin
        phase_r <= ROWS_NONE;
        col_r   <= '0;
        ocol_r  <= '0;
        orow_r  <= '0;
      end else begin
        col_r <= col_last ? '0 : col_r + mf3_pkg::COL_BITS'(1);
        if (col_last) begin
          unique case (phase_r)
            ROWS_NONE: phase_r <= ROWS_ONE;
            ROWS_ONE:  phase_r <= ROWS_MANY;
            default:   phase_r <= ROWS_MANY;
          endcase
        end
        if (emit) begin
          ocol_r <= ocol_last ? '0 : ocol_r + mf3_pkg::COL_BITS'(1);
          if (ocol_last) begin
            orow_r <= orow_r + mf3_pkg::ROW_BITS'(1);
          end
        end
      end
    end
  end

  `MF3_ASSERT(a_col_in_frame, (col_r <= w_m1_r) && (ocol_r <= w_m1_r), "column past frame width")
  `MF3_ASSERT(a_fend_on_border, q_push && q_item.fend |-> q_item.border && q_item.emit, "frame end off border")

endmodule

// ===== hdl/mf3_back.sv =====
`include "median_filter_3x3_defines.svh"

module mf3_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  mf3_pkg::item_t                 q_item,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mf3_pkg::TDATA_BITS-1:0] out_tdata,
  output logic                           out_tlast
);

  function automatic mf3_pkg::pixel_t min2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pixel_t max2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic mf3_pkg::pixel_t med3(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b,
                                           mf3_pkg::pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // line store: one word per column, mid row above top row
  logic [2*mf3_pkg::PIXEL_BITS-1:0] line_mem_r [mf3_pkg::MAX_WIDTH];
  logic [2*mf3_pkg::PIXEL_BITS-1:0] rd_r;
  logic [2*mf3_pkg::PIXEL_BITS-1:0] fwd_pair_r;
  logic                             fwd_r;

  logic                             b1_valid_r;
  mf3_pkg::item_t                   b1_item_r;
  logic                             b2_valid_r;
  logic                             b2_border_r;
  logic                             b2_fend_r;
  mf3_pkg::pixel_t                  win_r [mf3_pkg::WIN_SIZE];

  logic                             out_valid_r;
  mf3_pkg::pixel_t                  out_pixel_r;
  logic                             out_last_r;

  logic                             adv;
  logic [2*mf3_pkg::PIXEL_BITS-1:0] pair;
  logic [2*mf3_pkg::PIXEL_BITS-1:0] wr_pair;
  mf3_pkg::pixel_t                  top;
  mf3_pkg::pixel_t                  mid;
  mf3_pkg::pixel_t                  row_lo [3];
  mf3_pkg::pixel_t                  row_me [3];
  mf3_pkg::pixel_t                  row_hi [3];
  mf3_pkg::pixel_t                  median;

  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && !q_empty;

  // back-to-back access to the same column sees the write in flight
  assign pair    = fwd_r ? fwd_pair_r : rd_r;
  assign top     = pair[mf3_pkg::PIXEL_BITS-1:0];
  assign mid     = pair[2*mf3_pkg::PIXEL_BITS-1:mf3_pkg::PIXEL_BITS];
  assign wr_pair = {b1_item_r.pixel, mid};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r       <= line_mem_r[q_item.col];
      b1_item_r  <= q_item;
      fwd_pair_r <= wr_pair;
    end
    if (adv && b1_valid_r) begin
      line_mem_r[b1_item_r.col] <= wr_pair;
    end
  end

  // median of nine: sort rows, then max of mins, median of medians, min of maxes
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_lo[r] = min2(min2(win_r[r*3], win_r[r*3+1]), win_r[r*3+2]);
      row_me[r] = med3(win_r[r*3], win_r[r*3+1], win_r[r*3+2]);
      row_hi[r] = max2(max2(win_r[r*3], win_r[r*3+1]), win_r[r*3+2]);
    end
    median = med3(max2(max2(row_lo[0], row_lo[1]), row_lo[2]),
                  med3(row_me[0], row_me[1], row_me[2]),
                  min2(min2(row_hi[0], row_hi[1]), row_hi[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv) begin
      b1_valid_r  <= !q_empty;
      fwd_r       <= !q_empty && b1_valid_r && (b1_item_r.col == q_item.col);
      b2_valid_r  <= b1_valid_r && b1_item_r.emit;
      out_valid_r <= b2_valid_r;
      if (b1_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= top;
        win_r[5] <= mid;
        win_r[8] <= b1_item_r.pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_border_r <= b1_item_r.border;
      b2_fend_r   <= b1_item_r.fend;
      out_pixel_r <= b2_border_r ? win_r[mf3_pkg::WIN_MID] : median;
      out_last_r  <= b2_fend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mf3_pkg::TDATA_BITS'(out_pixel_r);
  assign out_tlast  = out_last_r;

  `MF3_ASSERT(a_fwd_has_item, fwd_r |-> b1_valid_r, "forward flag without item")
  `MF3_ASSERT_NEXT(a_b2_held, b2_valid_r && !adv, b2_valid_r, "result dropped while stalled")

endmodule

// ===== hdl/median_filter_3x3.sv =====
// channel  direction  handshake             payload
// in_      slave      in_tvalid/in_tready   tdata: pixel_in, tuser: flush
// out_     master     out_tvalid/out_tready tdata: pixel_out, tlast: frame_end
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// sustains one transaction per clock on every channel while out_tready is
// high; a result reaches the output register through the queue, the line
// store read and the median stage.
// rst_n is synchronous; no clearing pass, line store content is undefined
// until written. cfg_ready is always high.
// a stalled output only backs up the back end; the four-entry queue keeps
// in_tready high until it fills.
module median_filter_3x3 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mf3_pkg::TDATA_BITS-1:0]     in_tdata,   // [7:0] pixel_in
  input  logic                               in_tuser,   // [0] flush
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mf3_pkg::TDATA_BITS-1:0]     out_tdata,  // [7:0] pixel_out
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  mf3_pkg::item_t push_item;
  mf3_pkg::item_t pop_item;

  mf3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  mf3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 650;
  localparam int TIMEOUT_NS    = 1000000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    mf3_pkg::pixel_t pix;
    logic            fend;
  } px_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [mf3_pkg::TDATA_BITS-1:0]     in_tdata = '0;   // [7:0] pixel_in
  logic                               in_tuser = 1'b0; // [0] flush
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [mf3_pkg::TDATA_BITS-1:0]     out_tdata;       // [7:0] pixel_out
  logic                               out_tlast;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  median_filter_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state as the host sees it
  mf3_pkg::pixel_t                   line_mem [2*mf3_pkg::MAX_WIDTH];
  mf3_pkg::pixel_t                   win [mf3_pkg::WIN_SIZE];
  int unsigned                       next_col;
  int unsigned                       next_row;
  int unsigned                       next_out;
  logic [mf3_pkg::WIDTH_BITS-1:0]    width_reg =
    mf3_pkg::WIDTH_BITS'(mf3_pkg::RESET_WIDTH);
  logic [mf3_pkg::HEIGHT_BITS-1:0]   height_reg =
    mf3_pkg::HEIGHT_BITS'(mf3_pkg::RESET_HEIGHT);

  px_result_t expected_pixels[$];
  int         mismatch_count;
  int unsigned items_sent;
  bit         send_idle;
  bit         recv_idle;
  int         recv_hold;

  task automatic report_mismatch(input string msg);
    $display("[%0t] error: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > mf3_pkg::MAX_WIDTH) return mf3_pkg::MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > mf3_pkg::HEIGHT_LIMIT) return mf3_pkg::HEIGHT_LIMIT;
    return 32'(height_reg);
  endfunction

  function automatic mf3_pkg::pixel_t median_of(input mf3_pkg::pixel_t vals [mf3_pkg::WIN_SIZE]);
    mf3_pkg::pixel_t s [mf3_pkg::WIN_SIZE];
    mf3_pkg::pixel_t v;
    int              k;
    s = vals;
    for (int i = 1; i < mf3_pkg::WIN_SIZE; i++) begin
      v = s[i];
      k = i;
      while (k > 0 && s[k-1] > v) begin
        s[k] = s[k-1];
        k--;
      end
      s[k] = v;
    end
    return s[mf3_pkg::WIN_MID];
  endfunction

  function automatic void apply_register(input mf3_pkg::cfg_reg_t idx,
                                         input logic [mf3_pkg::CFG_DATA_BITS-1:0] val);
    case (idx)
      mf3_pkg::REG_FRAME_WIDTH:  width_reg = val[mf3_pkg::WIDTH_BITS-1:0];
      mf3_pkg::REG_FRAME_HEIGHT: height_reg = val[mf3_pkg::HEIGHT_BITS-1:0];
      default: ;
    endcase
    next_col = 0;
    next_row = 0;
    next_out = 0;
  endfunction

  function automatic void predict_median_output(input mf3_pkg::pixel_t pix, input bit flush);
    int unsigned     w, h, c;
    mf3_pkg::pixel_t x, top, mid, v;
    u64_t            pos, q, orow, ocol, last_idx;
    bit              border, fend;
    w = active_width();
    h = active_height();
    c = next_col;
    if (c >= w) c = 0;
    x = flush ? '0 : pix;
    top = line_mem[c];
    mid = line_mem[mf3_pkg::MAX_WIDTH + c];
    line_mem[c] = mid;
    line_mem[mf3_pkg::MAX_WIDTH + c] = x;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = x;
    pos = u64_t'(next_row) * w + c;
    c++;
    if (c >= w) begin
      c = 0;
      next_row++;
    end
    next_col = c;
    // results trail the input by one row and one pixel
    if (pos >= u64_t'(w) + 1) begin
      q = u64_t'(next_out);
      orow = q / w;
      ocol = q % w;
      last_idx = u64_t'(w) * h - 1;
      border = orow == 0 || orow == u64_t'(h) - 1 || ocol == 0 || ocol == u64_t'(w) - 1;
      v = border ? win[mf3_pkg::WIN_MID] : median_of(win);
      fend = (q == last_idx);
      expected_pixels.push_back('{pix: v, fend: fend});
      if (fend) begin
        next_col = 0;
        next_row = 0;
        next_out = 0;
      end else begin
        next_out = 32'(q + 1);
      end
    end
  endfunction

  task automatic send_item(input mf3_pkg::pixel_t pix, input bit flush);
    int gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mf3_pkg::TDATA_BITS'(pix);
    in_tuser <= flush;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    // transaction completes at the coming edge
    predict_median_output(pix, flush);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input mf3_pkg::cfg_reg_t idx,
                           input logic [mf3_pkg::CFG_DATA_BITS-1:0] val);
    wait_for_results();
    // trailing items of a cut-off frame may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    apply_register(idx, val);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned noise_pct);
    int unsigned n_pix;
    bit          flush;
    n_pix = w * h;
    for (int unsigned i = 0; i < n_pix + w + 1; i++) begin
      flush = (i >= n_pix);
      if ($urandom_range(0, 99) < noise_pct) flush = !flush;
      send_item(mf3_pkg::pixel_t'($urandom), flush);
    end
  endtask

  task automatic test_directed_frames();
    mf3_pkg::pixel_t corner_vals [9];
    corner_vals = '{8'd255, 8'd0, 8'd128, 8'd7, 8'd200, 8'd1, 8'd254, 8'd255, 8'd0};
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 3);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 3);
    foreach (corner_vals[i]) send_item(corner_vals[i], 1'b0);
    repeat (3) send_item(8'h00, 1'b1);
    // a pixel in the closing flush slot still ends the frame
    send_item(8'hA5, 1'b0);
    // 2x2 is all border; a flush stands in for one pixel
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 2);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 2);
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFE, 1'b0);
    send_item(8'h80, 1'b0);
    repeat (3) send_item(8'hFF, 1'b1);
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 1);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 1);
    send_item(8'hFF, 1'b0);
    repeat (2) send_item(8'h55, 1'b1);
  endtask

  task automatic test_register_limits();
    // zero saturates to a 1x1 frame
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 0);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 0);
    repeat (2) begin
      send_item(mf3_pkg::pixel_t'($urandom), 1'b0);
      repeat (2) send_item(mf3_pkg::pixel_t'($urandom), 1'b1);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
    // widest row: nothing is due inside the first row
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 2047);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 3);
    repeat (48) send_item(mf3_pkg::pixel_t'($urandom), 1'b0);
    // bits above the width field are dropped, leaving 4
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, '1);
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 21'h804);
    repeat (40) send_item(mf3_pkg::pixel_t'($urandom), 1'b0);
  endtask

  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(mf3_pkg::REG_FRAME_WIDTH, 6);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 5);
    recv_hold = 80;
    send_frame(6, 5, 0);
    wait_for_results();
    // stop offering mid frame until everything is out
    for (int i = 0; i < 37; i++) begin
      if (i == 20) wait_for_results();
      send_item(mf3_pkg::pixel_t'($urandom), i >= 30);
    end
  endtask

  task automatic test_random_frames();
    int unsigned w, h, sel, cut, start;
    logic [mf3_pkg::CFG_DATA_BITS-1:0] wval, hval;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      sel = $urandom_range(0, 99);
      w = sel < 80 ? $urandom_range(1, 8) : sel < 95 ? $urandom_range(9, 24)
                                                     : $urandom_range(25, 64);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
      wval = (w == 1 && $urandom_range(0, 1)) ? '0 : mf3_pkg::CFG_DATA_BITS'(w);
      hval = (h == 1 && $urandom_range(0, 1)) ? '0 : mf3_pkg::CFG_DATA_BITS'(h);
      if ($urandom_range(0, 1)) begin
        write_reg(mf3_pkg::REG_FRAME_WIDTH, wval);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, hval);
      end else begin
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, hval);
        write_reg(mf3_pkg::REG_FRAME_WIDTH, wval);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_frame(w, h, 0);
      end else if (sel < 85) begin
        send_frame(w, h, 0);
        send_frame(w, h, 0);
      end else if (sel < 93) begin
        send_frame(w, h, 5);
      end else begin
        // frame cut short, the next register write restarts it
        cut = $urandom_range(1, w * h + w);
        repeat (cut) send_item(mf3_pkg::pixel_t'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin : result_sink
    px_result_t want;
    int         gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 3) : 0;
      if (recv_hold > 0) begin
        out_tready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending",
                                  out_tdata[mf3_pkg::PIXEL_BITS-1:0]));
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[mf3_pkg::PIXEL_BITS-1:0] !== want.pix)
          report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                    out_tdata[mf3_pkg::PIXEL_BITS-1:0], want.pix));
        if (out_tlast !== want.fend)
          report_mismatch($sformatf("frame_end %b, expected %b", out_tlast, want.fend));
      end
      @(posedge clk);
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < 2*mf3_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_register_limits();
    test_output_backpressure();
    test_random_frames();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
